/* rtl/core/ppm_pkg.sv */
// ----------------------------------------------------------------------------
// ppm_pkg
// Types, register indexes and helpers shared by the point mapper.
// ----------------------------------------------------------------------------
package ppm_pkg;

    localparam int NUM_W   = 66;
    localparam int COEF_W  = 48;
    localparam int QW      = 17;
    localparam int OUT_W   = 16;
    localparam int CIDX_W  = 3;
    localparam int CDATA_W = 64;

    typedef enum logic [CIDX_W-1:0] {
        REG_X_GAIN_X = 3'd0,
        REG_X_GAIN_Y = 3'd1,
        REG_Y_GAIN_X = 3'd2,
        REG_Y_GAIN_Y = 3'd3,
        REG_PERSP_X  = 3'd4,
        REG_PERSP_Y  = 3'd5,
        REG_DEN_BASE = 3'd6,
        REG_OFFSETS  = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic signed [COEF_W-1:0] xgx;
        logic signed [COEF_W-1:0] xgy;
        logic signed [COEF_W-1:0] ygx;
        logic signed [COEF_W-1:0] ygy;
        logic signed [COEF_W-1:0] px;
        logic signed [COEF_W-1:0] py;
        logic signed [COEF_W-1:0] base;
        logic [CDATA_W-1:0]       offs;
    } t_coefs;

    typedef struct packed {
        logic [NUM_W-1:0] nx;
        logic [NUM_W-1:0] ny;
        logic [NUM_W-1:0] dm;
        logic             negx;
        logic             negy;
        logic             zero;
        logic             last;
        logic [QW-1:0]    qx;
        logic [QW-1:0]    qy;
    } t_div;

    // Returns {saturated, value} for a quotient magnitude and its sign.
    function automatic logic [OUT_W:0] clamp(input logic [QW-1:0] q, input logic neg);
        logic [OUT_W:0] r;
        if (neg) begin
            if (q > QW'(32768)) r = {1'b1, 16'h8000};
            else r = {1'b0, 16'(~q[OUT_W-1:0] + 16'd1)};
        end else begin
            if (q > QW'(32767)) r = {1'b1, 16'h7fff};
            else r = {1'b0, q[OUT_W-1:0]};
        end
        return r;
    endfunction

endpackage

/* rtl/core/ppm_if.sv */
// ----------------------------------------------------------------------------
// ppm_if
// Point, result and configuration channels of the point mapper.
// ----------------------------------------------------------------------------
interface ppm_pt_if #(parameter int COORD_BITS = 12) ();
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] x_in;
    logic [COORD_BITS-1:0] y_in;
    logic                  last_point;
    modport source (output valid, x_in, y_in, last_point, input ready);
    modport sink   (input valid, x_in, y_in, last_point, output ready);
endinterface

interface ppm_res_if ();
    logic               valid;
    logic               ready;
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic               range_flag;
    logic               last_out;
    modport source (output valid, out_x, out_y, range_flag, last_out, input ready);
    modport sink   (input valid, out_x, out_y, range_flag, last_out, output ready);
endinterface

interface ppm_cfg_if ();
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [63:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/core/ppm_front.sv */
// ----------------------------------------------------------------------------
// ppm_front
// Forms the numerators and denominator and splits them into sign and size.
// ----------------------------------------------------------------------------
module ppm_front #(
    parameter int COORD_BITS = 12
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  ppm_pkg::t_coefs         i_coefs,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [COORD_BITS-1:0]   i_x,
    input  logic [COORD_BITS-1:0]   i_y,
    input  logic                    i_last,
    output logic                    o_valid,
    input  logic                    i_ready,
    output ppm_pkg::t_div           o_d
);
    localparam int NW = ppm_pkg::NUM_W;
    localparam int PW = ppm_pkg::COEF_W + COORD_BITS + 1;

    logic                  r_av, r_bv, r_cv, r_dv;
    logic                  a_adv, b_adv, c_adv, d_adv;
    logic [COORD_BITS-1:0] r_x, r_y;
    logic                  r_alast, r_blast, r_clast;
    logic signed [NW-1:0]  r_pxx, r_pxy, r_pyx, r_pyy, r_ppx, r_ppy, r_base, r_ox, r_oy;
    logic signed [NW-1:0]  r_nx, r_ny, r_den;
    ppm_pkg::t_div         r_d, n_d;

    function automatic logic signed [NW-1:0] mul(
        input logic signed [ppm_pkg::COEF_W-1:0] c, input logic [COORD_BITS-1:0] v);
        logic signed [PW-1:0] p;
        p = c * $signed({1'b0, v});
        return {{(NW-PW){p[PW-1]}}, p};
    endfunction

    function automatic logic signed [NW-1:0] offs(input logic [31:0] h);
        return {{(NW-48){h[31]}}, h, 16'h0000};
    endfunction

    assign d_adv   = !r_dv || i_ready;
    assign c_adv   = !r_cv || d_adv;
    assign b_adv   = !r_bv || c_adv;
    assign a_adv   = !r_av || b_adv;
    assign o_ready = a_adv;
    assign o_valid = r_dv;
    assign o_d     = r_d;

    always_comb begin
        n_d      = '0;
        n_d.negx = r_nx[NW-1];
        n_d.negy = r_ny[NW-1];
        n_d.nx   = r_nx[NW-1] ? NW'(-r_nx) : NW'(r_nx);
        n_d.ny   = r_ny[NW-1] ? NW'(-r_ny) : NW'(r_ny);
        n_d.dm   = r_den[NW-1] ? NW'(-r_den) : NW'(r_den);
        n_d.negx = r_nx[NW-1] ^ r_den[NW-1];
        n_d.negy = r_ny[NW-1] ^ r_den[NW-1];
        n_d.zero = (r_den == '0);
        n_d.last = r_clast;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_av <= 1'b0;
            r_bv <= 1'b0;
            r_cv <= 1'b0;
            r_dv <= 1'b0;
        end else begin
            if (a_adv) r_av <= i_valid;
            if (b_adv) r_bv <= r_av;
            if (c_adv) r_cv <= r_bv;
            if (d_adv) r_dv <= r_cv;
        end
        if (a_adv && i_valid) begin
            r_x     <= i_x;
            r_y     <= i_y;
            r_alast <= i_last;
        end
        if (b_adv && r_av) begin
            r_pxx   <= mul(i_coefs.xgx, r_x);
            r_pxy   <= mul(i_coefs.xgy, r_y);
            r_pyx   <= mul(i_coefs.ygx, r_x);
            r_pyy   <= mul(i_coefs.ygy, r_y);
            r_ppx   <= mul(i_coefs.px, r_x);
            r_ppy   <= mul(i_coefs.py, r_y);
            r_base  <= {{(NW-ppm_pkg::COEF_W){i_coefs.base[ppm_pkg::COEF_W-1]}}, i_coefs.base};
            r_ox    <= offs(i_coefs.offs[31:0]);
            r_oy    <= offs(i_coefs.offs[63:32]);
            r_blast <= r_alast;
        end
        if (c_adv && r_bv) begin
            r_nx    <= r_pxx + r_pxy + r_ox;
            r_ny    <= r_pyx + r_pyy + r_oy;
            r_den   <= r_ppx + r_ppy + r_base;
            r_clast <= r_blast;
        end
        if (d_adv && r_cv) r_d <= n_d;
    end
endmodule

/* rtl/core/ppm_cell.sv */
// ----------------------------------------------------------------------------
// ppm_cell
// One restoring division step for both numerators against the shared divisor.
// ----------------------------------------------------------------------------
module ppm_cell #(
    parameter int SHIFT = 0
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  ppm_pkg::t_div i_d,
    output logic          o_valid,
    input  logic          i_ready,
    output ppm_pkg::t_div o_d
);
    localparam int NW = ppm_pkg::NUM_W;
    localparam int WW = NW + ppm_pkg::QW;

    logic          r_valid;
    ppm_pkg::t_div r_d, n_d;
    logic [WW-1:0] dsh, wx, wy;
    logic          gex, gey;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_d     = r_d;

    always_comb begin
        dsh     = WW'(i_d.dm) << SHIFT;
        wx      = WW'(i_d.nx);
        wy      = WW'(i_d.ny);
        gex     = (wx >= dsh);
        gey     = (wy >= dsh);
        n_d     = i_d;
        n_d.nx  = gex ? NW'(wx - dsh) : i_d.nx;
        n_d.ny  = gey ? NW'(wy - dsh) : i_d.ny;
        n_d.qx  = {i_d.qx[ppm_pkg::QW-2:0], gex};
        n_d.qy  = {i_d.qy[ppm_pkg::QW-2:0], gey};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) r_d <= n_d;
    end
endmodule

/* rtl/core/perspective_point_map_top.sv */
// ----------------------------------------------------------------------------
// perspective_point_map_top
// Projective point transform with a pipelined divider built from a row of cells.
// ----------------------------------------------------------------------------
// The block takes one point per clock unless the result channel stalls it, and
// returns one result per point, in order. Four front stages form the products,
// the sums and their magnitudes; seventeen division cells each resolve one
// quotient bit; a last register holds the result beat, clamped to 16 bits
// with overflow flagged. Config writes are always taken and registered.
// ----------------------------------------------------------------------------
module perspective_point_map_top #(
    parameter int COORD_BITS = 12
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ppm_pt_if.sink    i_pt,
    ppm_res_if.source o_res,
    ppm_cfg_if.sink   i_cfg
);
    localparam int NC = ppm_pkg::QW;

    ppm_pkg::t_coefs r_coefs;
    ppm_pkg::t_div   c_d [NC+1];
    logic            c_v [NC+1];
    logic            c_r [NC+1];
    logic            r_ov, o_adv;
    logic [15:0]     r_ox, r_oy;
    logic            r_flag, r_last;
    logic [16:0]     cx, cy;
    ppm_pkg::t_div   fin;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coefs.xgx  <= 48'sh1_0000_0000;
            r_coefs.xgy  <= '0;
            r_coefs.ygx  <= '0;
            r_coefs.ygy  <= 48'sh1_0000_0000;
            r_coefs.px   <= '0;
            r_coefs.py   <= '0;
            r_coefs.base <= 48'sh1_0000_0000;
            r_coefs.offs <= '0;
        end else if (i_cfg.valid) begin
            unique case (ppm_pkg::t_reg_idx'(i_cfg.index))
                ppm_pkg::REG_X_GAIN_X: r_coefs.xgx  <= i_cfg.data[47:0];
                ppm_pkg::REG_X_GAIN_Y: r_coefs.xgy  <= i_cfg.data[47:0];
                ppm_pkg::REG_Y_GAIN_X: r_coefs.ygx  <= i_cfg.data[47:0];
                ppm_pkg::REG_Y_GAIN_Y: r_coefs.ygy  <= i_cfg.data[47:0];
                ppm_pkg::REG_PERSP_X:  r_coefs.px   <= i_cfg.data[47:0];
                ppm_pkg::REG_PERSP_Y:  r_coefs.py   <= i_cfg.data[47:0];
                ppm_pkg::REG_DEN_BASE: r_coefs.base <= i_cfg.data[47:0];
                ppm_pkg::REG_OFFSETS:  r_coefs.offs <= i_cfg.data;
                default: ;
            endcase
        end
    end

    ppm_front #(.COORD_BITS(COORD_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_coefs (r_coefs),
        .i_valid (i_pt.valid),
        .o_ready (i_pt.ready),
        .i_x     (i_pt.x_in),
        .i_y     (i_pt.y_in),
        .i_last  (i_pt.last_point),
        .o_valid (c_v[0]),
        .i_ready (c_r[0]),
        .o_d     (c_d[0])
    );

    for (genvar g = 0; g < NC; g++) begin : g_cell
        ppm_cell #(.SHIFT(NC - 1 - g)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (c_v[g]),
            .o_ready (c_r[g]),
            .i_d     (c_d[g]),
            .o_valid (c_v[g+1]),
            .i_ready (c_r[g+1]),
            .o_d     (c_d[g+1])
        );
    end

    assign o_adv   = !r_ov || o_res.ready;
    assign c_r[NC] = o_adv;
    assign fin     = c_d[NC];

    always_comb begin
        cx = ppm_pkg::clamp(fin.qx, fin.negx);
        cy = ppm_pkg::clamp(fin.qy, fin.negy);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (o_adv) begin
            r_ov <= c_v[NC];
        end
        if (o_adv && c_v[NC]) begin
            r_ox   <= fin.zero ? 16'h0000 : cx[15:0];
            r_oy   <= fin.zero ? 16'h0000 : cy[15:0];
            r_flag <= fin.zero || cx[16] || cy[16];
            r_last <= fin.last;
        end
    end

    assign o_res.valid      = r_ov;
    assign o_res.out_x      = r_ox;
    assign o_res.out_y      = r_oy;
    assign o_res.range_flag = r_flag;
    assign o_res.last_out   = r_last;
endmodule
